FILE: design/binary_to_ascii_decimal_top_macros.svh
// Assertion macros shared by the binary to ASCII decimal converter.
// Each macro checks an implication under the asynchronous active-low reset.
`ifndef BINARY_TO_ASCII_DECIMAL_TOP_MACROS_SVH
`define BINARY_TO_ASCII_DECIMAL_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define B2AD_ASSERT_IMP(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
        else $error("b2ad: same-cycle check failed");

// Next-cycle implication.
`define B2AD_ASSERT_NXT(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) \
        else $error("b2ad: next-cycle check failed");

`else

`define B2AD_ASSERT_IMP(label, clock, reset_n, ante, cons)
`define B2AD_ASSERT_NXT(label, clock, reset_n, ante, cons)

`endif

`endif

FILE: design/b2ad_pkg.sv
package b2ad_pkg;

    // Default width of the binary input value.
    localparam int NUMBER_WIDTH_DEF = 32;

    // Number of decimal digit cells; larger values are reduced modulo 10^10.
    localparam int MAX_DIGITS = 10;

    // Width of a counter that holds 0 to MAX_DIGITS.
    localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);

    localparam logic [3:0] BCD_FIVE   = 4'd5;
    localparam logic [3:0] BCD_THREE  = 4'd3;
    localparam logic [5:0] ASCII_ZERO = 6'd48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } b2ad_state_t;

    // Command that every digit cell receives in a cycle.
    typedef struct packed {
        logic clear;   // load zero
        logic dabble;  // correct and shift in one binary bit
        logic shift;   // take the digit of the lower neighbor
    } b2ad_cell_ctrl_t;

endpackage

FILE: design/b2ad_cell.sv
// One BCD digit of the conversion chain.
module b2ad_cell
    import b2ad_pkg::*;
(
    input  logic            clk,
    input  b2ad_cell_ctrl_t ctrl,
    input  logic            bit_in,     // binary bit from the lower neighbor
    input  logic [3:0]      digit_in,   // digit of the lower neighbor
    output logic            bit_out,    // bit handed to the upper neighbor
    output logic [3:0]      digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adjusted;

    // A digit of five or more becomes ten or more when doubled, so it is
    // biased by three first and the overflow leaves through the top bit.
    assign adjusted = (digit_reg >= BCD_FIVE) ? digit_reg + BCD_THREE : digit_reg;
    assign bit_out  = adjusted[3];
    assign digit    = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = 4'd0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adjusted[2:0], bit_in};
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

FILE: design/binary_to_ascii_decimal_top.sv
// Binary to ASCII decimal converter. Each input word carries one unsigned
// NUMBER_WIDTH-bit value; the block answers with its decimal digits as ASCII
// codes '0' to '9', most significant first, with leading zeros suppressed and
// the final digit marked by m_tlast. Zero gives the single character '0'.
// Values beyond ten decimal digits (only possible when NUMBER_WIDTH exceeds
// 33) are reduced modulo 10^10. The conversion runs through a chain of ten
// BCD digit cells using shift-and-add-three: one input bit enters the chain
// per cycle until all NUMBER_WIDTH bits are in. The chain then shifts up one
// digit per cycle, pausing while the output register is full and not taken,
// through all ten digit places, producing a character or dropping a leading
// zero each time. A new number is taken only once all ten places are done.
// The output register lets a new number be accepted while the last
// character of the previous one still waits to be taken.
`include "binary_to_ascii_decimal_top_macros.svh"

module binary_to_ascii_decimal_top
    import b2ad_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Input stream.
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((NUMBER_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // [NUMBER_WIDTH-1:0] number
    // Output stream.
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [7:0]                              m_tdata,   // [5:0] digit_char
    output logic                                    m_tlast    // last_digit
);

    localparam int CNT_W = $clog2(NUMBER_WIDTH);
    localparam logic [CNT_W-1:0] BIT_LAST = CNT_W'(NUMBER_WIDTH - 1);
    localparam logic [DIGIT_CNT_W-1:0] DIGITS_ALL = DIGIT_CNT_W'(MAX_DIGITS);
    localparam logic [DIGIT_CNT_W-1:0] DIGITS_ONE = DIGIT_CNT_W'(1);

    b2ad_state_t                state_reg, state_next;
    logic [NUMBER_WIDTH-1:0]    bin_reg, bin_next;
    logic [CNT_W-1:0]           bit_cnt_reg, bit_cnt_next;
    logic [DIGIT_CNT_W-1:0]     remain_reg, remain_next;
    logic                       started_reg, started_next;
    logic                       out_valid_reg, out_valid_next;
    logic [5:0]                 out_char_reg, out_char_next;
    logic                       out_last_reg, out_last_next;

    b2ad_cell_ctrl_t            cell_ctrl;
    logic                       carry [MAX_DIGITS];
    logic [3:0]                 digit [MAX_DIGITS];

    logic                       in_accept;
    logic                       slot_free;
    logic                       skip_zero;
    logic [3:0]                 top_digit;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;
    assign top_digit = digit[MAX_DIGITS-1];
    // A leading zero is dropped while no digit has been shown and more follow.
    assign skip_zero = (top_digit == 4'd0) && !started_reg && (remain_reg > DIGITS_ONE);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_char_reg};
    assign m_tlast  = out_last_reg;

    // The binary value enters the lowest cell most significant bit first.
    assign carry[0] = bin_reg[NUMBER_WIDTH-1];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_DIGITS; gi++)
        begin : g_cell
            if (gi == MAX_DIGITS - 1)
            begin : g_top
                // Overflow out of the top digit is dropped: modulo 10^10.
                b2ad_cell u_cell (
                    .clk      (clk),
                    .ctrl     (cell_ctrl),
                    .bit_in   (carry[gi]),
                    .digit_in (digit[gi-1]),
                    .bit_out  (),
                    .digit    (digit[gi])
                );
            end
            else if (gi == 0)
            begin : g_low
                b2ad_cell u_cell (
                    .clk      (clk),
                    .ctrl     (cell_ctrl),
                    .bit_in   (carry[gi]),
                    .digit_in (4'd0),
                    .bit_out  (carry[gi+1]),
                    .digit    (digit[gi])
                );
            end
            else
            begin : g_mid
                b2ad_cell u_cell (
                    .clk      (clk),
                    .ctrl     (cell_ctrl),
                    .bit_in   (carry[gi]),
                    .digit_in (digit[gi-1]),
                    .bit_out  (carry[gi+1]),
                    .digit    (digit[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        bit_cnt_next   = bit_cnt_reg;
        remain_next    = remain_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        cell_ctrl      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    bin_next        = s_tdata[NUMBER_WIDTH-1:0];
                    bit_cnt_next    = BIT_LAST;
                    cell_ctrl.clear = 1'b1;
                    state_next      = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                cell_ctrl.dabble = 1'b1;
                bin_next         = {bin_reg[NUMBER_WIDTH-2:0], 1'b0};
                bit_cnt_next     = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    remain_next  = DIGITS_ALL;
                    started_next = 1'b0;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cell_ctrl.shift = 1'b1;
                    remain_next     = remain_reg - 1'b1;
                    if (!skip_zero)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = {2'b00, top_digit} + ASCII_ZERO;
                        out_last_next  = (remain_reg == DIGITS_ONE);
                        started_next   = 1'b1;
                    end
                    if (remain_reg == DIGITS_ONE)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            remain_reg    <= '0;
            started_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            remain_reg    <= remain_next;
            started_reg   <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    // Only decimal digit codes ever leave the block.
    `B2AD_ASSERT_IMP(a_char_is_digit, clk, rst_n, out_valid_reg,
        (out_char_reg >= ASCII_ZERO) && (out_char_reg <= ASCII_ZERO + 6'd9))
    // An accepted number goes straight into conversion.
    `B2AD_ASSERT_NXT(a_accept_converts, clk, rst_n, in_accept, state_reg == ST_CONVERT)
    // After the last input bit the chain starts emitting all ten digit places.
    `B2AD_ASSERT_NXT(a_convert_done, clk, rst_n,
        (state_reg == ST_CONVERT) && (bit_cnt_reg == '0),
        (state_reg == ST_EMIT) && (remain_reg == DIGITS_ALL) && !started_reg)
    // The final digit place is always shown, flagged as last, and ends the number.
    `B2AD_ASSERT_NXT(a_last_shown, clk, rst_n,
        (state_reg == ST_EMIT) && slot_free && (remain_reg == DIGITS_ONE),
        out_valid_reg && out_last_reg && (state_reg == ST_IDLE))

endmodule
